// ----- rtl/core/kmf_pkg.sv -----
// shared types and constants for the keyword mask-or-reset filter
`default_nettype none

package kmf_pkg;

  // request beat: one stream byte write or one filtered byte read
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       chunk_end;
  } req_beat_t;

  // response beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_chunk;
    logic [1:0] status;
  } rsp_beat_t;

  // controls for the keyword window
  typedef struct packed {
    logic shift;
    logic flush;
  } match_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MASK
  } kmf_state_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] STATUS_DATA   = 2'd0;
  localparam logic [1:0] STATUS_READY  = 2'd1;
  localparam logic [1:0] STATUS_CLOSED = 2'd2;

  localparam logic [1:0] MODE_RESET = 2'd0;
  localparam logic [1:0] MODE_MASK  = 2'd1;

  localparam logic [2:0] REG_KEY_LOW   = 3'd0;
  localparam logic [2:0] REG_KEY_HIGH  = 3'd1;
  localparam logic [2:0] REG_KEY_LEN   = 3'd2;
  localparam logic [2:0] REG_MODE      = 3'd3;
  localparam logic [2:0] REG_MASK_XTRA = 3'd4;

  localparam logic [7:0] MASK_CHAR    = 8'h2A;
  localparam logic [4:0] SINCE_MAX    = 5'd31;
  localparam int         KEY_BYTES    = 16;

endpackage

`default_nettype wire

// ----- rtl/core/keyword_mask_or_reset_filter.sv -----
// top level: chunk buffer keyword filter with mask or reset on match
`default_nettype none

// channel | role                          | handshake
// --------+-------------------------------+---------------------------------
// req     | byte write or filtered read   | req_valid / req_stall, req_beat
// rsp     | drained byte or chunk status  | rsp_valid / rsp_stall, rsp_beat
// cfg     | keyword, length, mode, extra  | cfg_we, cfg_index, cfg_data
//
// a write beat is taken in ST_IDLE; a masking match also rewrites the earlier
// keyword_length - 1 stored keyword bytes in ST_MASK, one at a time through the single ram write port
// a read beat passes through ST_READ to pick up the registered ram read
// rst is synchronous; no clearing pass, the chunk store is read only where
// written in the current chunk
// req stalls while a beat is in work or a response waits under rsp_stall

module keyword_mask_or_reset_filter
  import kmf_pkg::*;
#(
  parameter int CHUNK_DEPTH = 4096,
  parameter int MAX_KEY_LEN = 16
) (
  input  wire         clk,
  input  wire         rst,
  // configuration
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [63:0] cfg_data,
  // request channel
  input  wire         req_valid,
  output logic        req_stall,
  input  wire  req_beat_t req_beat,
  // response channel
  output logic        rsp_valid,
  input  wire         rsp_stall,
  output rsp_beat_t   rsp_beat
);

  localparam int AW = $clog2(CHUNK_DEPTH);
  localparam int CW = $clog2(CHUNK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(CHUNK_DEPTH);
  localparam logic [4:0]    LEN_CAP   = 5'(MAX_KEY_LEN);

  // configuration registers
  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [4:0]  key_len_reg;
  logic [1:0]  mode;
  logic [7:0]  mask_extra;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= 64'd0;
      key_high    <= 64'd0;
      key_len_reg <= 5'd1;
      mode        <= MODE_MASK;
      mask_extra  <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW:   key_low     <= cfg_data;
        REG_KEY_HIGH:  key_high    <= cfg_data;
        REG_KEY_LEN:   key_len_reg <= cfg_data[4:0];
        REG_MODE:      mode        <= cfg_data[1:0];
        REG_MASK_XTRA: mask_extra  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective keyword length, saturated to the window size
  logic [4:0] key_len;
  assign key_len = (key_len_reg > LEN_CAP) ? LEN_CAP : key_len_reg;

  // control state
  kmf_state_t    state, state_next;
  logic [CW-1:0] write_count, write_count_next;
  logic [CW-1:0] read_position, read_position_next;
  logic [4:0]    since_mask, since_mask_next;
  logic [7:0]    mask_remaining, mask_remaining_next;
  logic          match_seen, match_seen_next;
  logic          draining, draining_next;
  logic          closed, closed_next;
  logic [AW-1:0] mask_ptr, mask_ptr_next;
  logic [4:0]    mask_left, mask_left_next;
  logic          pend_last, pend_last_next;
  logic          rsp_valid_next;
  rsp_beat_t     rsp_beat_next;

  // ram port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  match_ctrl_t   mctrl;
  logic          key_hit;

  logic          accept;
  logic          rsp_take;
  logic [4:0]    since_inc;
  logic [CW-1:0] wc_inc;
  logic [CW-1:0] rp_inc;

  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign since_inc = (since_mask < SINCE_MAX) ? since_mask + 5'd1 : since_mask;
  assign wc_inc    = write_count + CW'(1);
  assign rp_inc    = read_position + CW'(1);

  always_comb begin
    state_next          = state;
    write_count_next    = write_count;
    read_position_next  = read_position;
    since_mask_next     = since_mask;
    mask_remaining_next = mask_remaining;
    match_seen_next     = match_seen;
    draining_next       = draining;
    closed_next         = closed;
    mask_ptr_next       = mask_ptr;
    mask_left_next      = mask_left;
    pend_last_next      = pend_last;
    rsp_valid_next      = rsp_take ? 1'b0 : rsp_valid;
    rsp_beat_next       = rsp_beat;
    ram_we              = 1'b0;
    ram_waddr           = write_count[AW-1:0];
    ram_wdata           = req_beat.data_byte;
    ram_raddr           = read_position[AW-1:0];
    mctrl.shift         = 1'b0;
    mctrl.flush         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (closed) begin
            // closed until reset: every beat answers closed
            rsp_valid_next = 1'b1;
            rsp_beat_next  = '{out_byte: 8'd0, last_of_chunk: 1'b0, status: STATUS_CLOSED};
          end else if (req_beat.operation == OP_READ) begin
            if (draining && read_position < write_count) begin
              read_position_next = rp_inc;
              pend_last_next     = (rp_inc >= write_count);
              state_next         = ST_READ;
              if (rp_inc >= write_count) begin
                // final byte: drop back to collecting a new chunk
                draining_next       = 1'b0;
                write_count_next    = '0;
                read_position_next  = '0;
                since_mask_next     = 5'd0;
                mask_remaining_next = 8'd0;
                match_seen_next     = 1'b0;
                mctrl.flush         = 1'b1;
              end
            end
          end else if (!draining && write_count < DEPTH_CNT) begin
            ram_we = 1'b1;
            if (mask_remaining != 8'd0) begin
              // inside a masked span: byte replaced, window untouched
              ram_wdata           = MASK_CHAR;
              mask_remaining_next = mask_remaining - 8'd1;
            end else begin
              mctrl.shift     = 1'b1;
              since_mask_next = since_inc;
              if ((mode == MODE_RESET || mode == MODE_MASK) &&
                  since_inc >= key_len && key_hit) begin
                if (mode == MODE_RESET) begin
                  match_seen_next = 1'b1;
                end else begin
                  ram_wdata           = MASK_CHAR;
                  mask_remaining_next = mask_extra;
                  since_mask_next     = 5'd0;
                  if (key_len > 5'd1) begin
                    // earlier keyword bytes get rewritten one per cycle
                    mask_ptr_next  = write_count[AW-1:0] - AW'(1);
                    mask_left_next = key_len - 5'd1;
                    state_next     = ST_MASK;
                  end
                end
              end
            end
            write_count_next = wc_inc;

            if (req_beat.chunk_end || wc_inc >= DEPTH_CNT) begin
              rsp_valid_next = 1'b1;
              if (match_seen_next) begin
                closed_next         = 1'b1;
                write_count_next    = '0;
                read_position_next  = '0;
                since_mask_next     = 5'd0;
                mask_remaining_next = 8'd0;
                match_seen_next     = 1'b0;
                mctrl.flush         = 1'b1;
                rsp_beat_next = '{out_byte: 8'd0, last_of_chunk: 1'b0,
                                  status: STATUS_CLOSED};
              end else begin
                mask_remaining_next = 8'd0;
                draining_next       = 1'b1;
                read_position_next  = '0;
                rsp_beat_next = '{out_byte: 8'd0, last_of_chunk: 1'b0,
                                  status: STATUS_READY};
              end
            end
          end
        end
      end

      ST_READ: begin
        // ram data for the read issued last cycle
        rsp_valid_next = 1'b1;
        rsp_beat_next  = '{out_byte: ram_rdata, last_of_chunk: pend_last,
                           status: STATUS_DATA};
        state_next     = ST_IDLE;
      end

      ST_MASK: begin
        ram_we         = 1'b1;
        ram_waddr      = mask_ptr;
        ram_wdata      = MASK_CHAR;
        mask_ptr_next  = mask_ptr - AW'(1);
        mask_left_next = mask_left - 5'd1;
        if (mask_left == 5'd1) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count    <= '0;
      read_position  <= '0;
      since_mask     <= 5'd0;
      mask_remaining <= 8'd0;
      match_seen     <= 1'b0;
      draining       <= 1'b0;
      closed         <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      write_count    <= write_count_next;
      read_position  <= read_position_next;
      since_mask     <= since_mask_next;
      mask_remaining <= mask_remaining_next;
      match_seen     <= match_seen_next;
      draining       <= draining_next;
      closed         <= closed_next;
      rsp_valid      <= rsp_valid_next;
    end
  end

  // payload and sequencer registers
  always_ff @(posedge clk) begin
    mask_ptr  <= mask_ptr_next;
    mask_left <= mask_left_next;
    pend_last <= pend_last_next;
    rsp_beat  <= rsp_beat_next;
  end

  kmf_match #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_match (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mctrl),
    .new_byte (req_beat.data_byte),
    .key      ({key_high, key_low}),
    .key_len  (key_len),
    .hit      (key_hit)
  );

  kmf_ram #(
    .WIDTH (8),
    .DEPTH (CHUNK_DEPTH)
  ) u_chunk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/kmf_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none

module kmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/kmf_match.sv -----
// keyword window: last bytes written and compare against the keyword
`default_nettype none

module kmf_match
  import kmf_pkg::*;
#(
  parameter int MAX_KEY_LEN = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  match_ctrl_t            ctrl,
  input  wire  [7:0]                   new_byte,
  input  wire  [8*KEY_BYTES-1:0]       key,
  input  wire  [4:0]                   key_len,
  output logic                         hit
);

  logic [7:0] recent      [MAX_KEY_LEN];
  logic [7:0] recent_next [MAX_KEY_LEN];
  logic [7:0] key_arr     [KEY_BYTES];

  // window as it stands after the incoming byte
  always_comb begin
    recent_next[0] = new_byte;
    for (int j = 1; j < MAX_KEY_LEN; j++) begin
      recent_next[j] = recent[j-1];
    end
    for (int k = 0; k < KEY_BYTES; k++) begin
      key_arr[k] = key[8*k +: 8];
    end
  end

  // newest byte pairs with the last keyword byte
  always_comb begin
    logic [4:0] idx;
    hit = (key_len != 5'd0);
    for (int j = 0; j < MAX_KEY_LEN; j++) begin
      idx = key_len - 5'd1 - 5'(j);
      if (5'(j) < key_len && recent_next[j] != key_arr[idx[3:0]]) begin
        hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      for (int j = 0; j < MAX_KEY_LEN; j++) begin
        recent[j] <= 8'd0;
      end
    end else if (ctrl.shift) begin
      for (int j = 0; j < MAX_KEY_LEN; j++) begin
        recent[j] <= recent_next[j];
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// testbench for the keyword mask-or-reset filter: directed and random chunks against a model
`timescale 1ns / 100ps

module testbench;
  import kmf_pkg::*;

  localparam int         STORE_DEPTH   = 4096;
  localparam int         KEY_MAX       = 16;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         RANDOM_BEATS  = 1400;
  localparam logic [1:0] MODE_PASS     = 2'd2;
  localparam logic [1:0] MODE_PASS_ALT = 2'd3;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_KEY_LOW;
  logic [63:0] cfg_data  = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_beat_t   req_beat  = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_beat_t   rsp_beat;

  // idling on both sides is enabled while this is set
  bit gaps_on = 1'b1;
  int stall_left = 0;
  int mismatch_count = 0;

  // filter state as seen from outside
  logic [127:0] key_bits   = '0;
  logic [4:0]   key_len    = 5'd1;
  logic [1:0]   mode_sel   = MODE_MASK;
  logic [7:0]   star_extra = 8'd20;

  logic [7:0]   buf_mem [STORE_DEPTH];
  logic [7:0]   key_window [KEY_MAX];
  int           fill_count = 0;
  int           drain_pos  = 0;
  int           since_span = 0;
  int           star_left  = 0;
  bit           hit_seen   = 1'b0;
  bit           in_drain   = 1'b0;
  bit           shut       = 1'b0;

  // filtered beats still to come out of the block, oldest first
  rsp_beat_t filter_out_q [$];

  keyword_mask_or_reset_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_beat  (req_beat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_beat  (rsp_beat)
  );

  always #10 clk = ~clk;

  initial begin
    for (int k = 0; k < KEY_MAX; k++) key_window[k] = 8'h00;
  end

  // ---------------------------------------------------------------------------
  // filter behavior
  // ---------------------------------------------------------------------------

  function automatic void open_chunk();
    fill_count = 0;
    drain_pos  = 0;
    for (int k = 0; k < KEY_MAX; k++) key_window[k] = 8'h00;
    since_span = 0;
    star_left  = 0;
    hit_seen   = 1'b0;
  endfunction

  // advance the filter by one accepted request beat, queue what it emits
  function automatic void apply_filter(input req_beat_t b);
    rsp_beat_t r;
    int        span;
    bit        hit;
    r = '0;
    // a closed block answers every beat with the closed status
    if (shut) begin
      r.status = STATUS_CLOSED;
      filter_out_q.push_back(r);
      return;
    end
    if (b.operation == OP_READ) begin
      // reads outside a drain are dropped
      if (!in_drain || drain_pos >= fill_count) return;
      r.out_byte = buf_mem[drain_pos];
      drain_pos++;
      r.last_of_chunk = (drain_pos >= fill_count);
      r.status = STATUS_DATA;
      filter_out_q.push_back(r);
      if (r.last_of_chunk) begin
        in_drain = 1'b0;
        open_chunk();
      end
      return;
    end
    // writes during a drain are dropped
    if (in_drain || fill_count >= STORE_DEPTH) return;
    if (star_left > 0) begin
      // inside the masked tail: byte is replaced, keyword search paused
      buf_mem[fill_count] = MASK_CHAR;
      star_left--;
    end else begin
      span = (key_len > KEY_MAX) ? KEY_MAX : int'(key_len);
      buf_mem[fill_count] = b.data_byte;
      for (int k = KEY_MAX - 1; k > 0; k--) key_window[k] = key_window[k - 1];
      key_window[0] = b.data_byte;
      if (since_span < 31) since_span++;
      // a match must start at or after the end of the last masked span
      hit = (mode_sel == MODE_RESET || mode_sel == MODE_MASK) && span > 0 &&
            since_span >= span;
      for (int k = 0; k < span; k++)
        if (key_window[span - 1 - k] != key_bits[8 * k +: 8]) hit = 1'b0;
      if (hit) begin
        if (mode_sel == MODE_RESET) begin
          hit_seen = 1'b1;
        end else begin
          for (int k = 0; k < span; k++) buf_mem[fill_count - k] = MASK_CHAR;
          star_left  = star_extra;
          since_span = 0;
        end
      end
    end
    fill_count++;
    // chunk closes on the end flag or on a full store
    if (b.chunk_end || fill_count >= STORE_DEPTH) begin
      if (hit_seen) begin
        shut = 1'b1;
        open_chunk();
        r.status = STATUS_CLOSED;
      end else begin
        star_left = 0;
        in_drain  = 1'b1;
        drain_pos = 0;
        r.status  = STATUS_READY;
      end
      filter_out_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // response side: random stall bursts and beat comparison
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || !gaps_on) begin
      stall_left <= 0;
      rsp_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      // start a stall burst of random length
      stall_left <= $urandom_range(0, 6);
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rsp_beat_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (filter_out_q.size() == 0) begin
        $error("response beat with nothing pending: out_byte %0h last %0b status %0d",
               rsp_beat.out_byte, rsp_beat.last_of_chunk, rsp_beat.status);
        mismatch_count++;
      end else begin
        want = filter_out_q.pop_front();
        if (rsp_beat.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", want.out_byte, rsp_beat.out_byte);
          mismatch_count++;
        end
        if (rsp_beat.last_of_chunk !== want.last_of_chunk) begin
          $error("last_of_chunk: expected %0b, actual %0b",
                 want.last_of_chunk, rsp_beat.last_of_chunk);
          mismatch_count++;
        end
        if (rsp_beat.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_beat.status);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // valid stays high after a beat is taken; any pause lowers it first
  task automatic send_beat(input logic op, input logic [7:0] data, input logic last);
    req_beat_t b;
    int        gap;
    b.operation = op;
    b.data_byte = data;
    b.chunk_end = last;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_beat  <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_filter(b);
  endtask

  // hold off until every pending beat is out, then let a keyword rewrite finish
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (filter_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all five registers back to back; only called while idle
  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input logic [1:0] mode,
                            input logic [7:0] extra);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_KEY_LEN;
    cfg_data  <= 64'(len);
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_data  <= 64'(mode);
    @(posedge clk);
    cfg_index <= REG_MASK_XTRA;
    cfg_data  <= 64'(extra);
    @(posedge clk);
    cfg_we     <= 1'b0;
    key_bits   = {hi, lo};
    key_len    = len;
    mode_sel   = mode;
    star_extra = extra;
  endtask

  task automatic random_config(input bit keep_mode);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [1:0]  mode;
    logic [7:0]  extra;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    // zero length never matches, above sixteen saturates
    case ($urandom_range(0, 7))
      0:       len = 5'd0;
      1:       len = 5'd16;
      2:       len = 5'($urandom_range(17, 31));
      3, 4:    len = 5'($urandom_range(1, 16));
      default: len = 5'($urandom_range(1, 4));
    endcase
    if (keep_mode) begin
      mode = mode_sel;
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    mode = MODE_RESET;
        2:       mode = MODE_PASS;
        3:       mode = MODE_PASS_ALT;
        default: mode = MODE_MASK;
      endcase
    end
    case ($urandom_range(0, 5))
      0:       extra = 8'd0;
      1:       extra = 8'd255;
      default: extra = 8'($urandom_range(0, 30));
    endcase
    // reset mode keywords keep bit 7 set so 7-bit stream data never trips them
    if (mode == MODE_RESET) begin
      lo = lo | {8{8'h80}};
      hi = hi | {8{8'h80}};
    end
    set_config(lo, hi, len, mode, extra);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers: one-byte keyword 00, mask mode, 20 trailing bytes
  task automatic test_reset_defaults();
    send_beat(OP_READ, 8'hFF, 1'b1);    // nothing to drain yet
    send_beat(OP_WRITE, 8'hFF, 1'b0);
    send_beat(OP_WRITE, 8'h00, 1'b0);   // keyword hit
    send_beat(OP_WRITE, 8'h7E, 1'b1);   // inside masked tail, closes chunk
    send_beat(OP_WRITE, 8'h00, 1'b1);   // dropped while draining
    repeat (3) send_beat(OP_READ, 8'h00, 1'b0);
  endtask

  // keyword "ab", longest tail: second hit swallowed, tail cut at chunk end
  task automatic test_mask_clipping();
    wait_idle();
    set_config(64'h6261, 64'h0, 5'd2, MODE_MASK, 8'd255);
    send_beat(OP_WRITE, 8'h78, 1'b0);
    send_beat(OP_WRITE, 8'h61, 1'b0);
    send_beat(OP_WRITE, 8'h62, 1'b0);
    send_beat(OP_WRITE, 8'h61, 1'b0);
    send_beat(OP_WRITE, 8'h62, 1'b1);
    repeat (5) send_beat(OP_READ, 8'h00, 1'b0);
  endtask

  // mode value 3 leaves keyword bytes alone
  task automatic test_pass_through();
    wait_idle();
    set_config(64'h6261, 64'h0, 5'd2, MODE_PASS_ALT, 8'd0);
    send_beat(OP_WRITE, 8'h61, 1'b0);
    send_beat(OP_WRITE, 8'h62, 1'b1);
    repeat (2) send_beat(OP_READ, 8'h00, 1'b0);
  endtask

  // random configs and chunks, noise beats in between
  task automatic test_random_traffic();
    int         beats_done;
    int         n;
    int         span;
    int         cut;
    logic       last;
    logic [7:0] rb;
    logic [7:0] bytes_q [$];
    beats_done = 0;
    while (beats_done < RANDOM_BEATS) begin
      wait_idle();
      // final stretch runs without idling
      gaps_on = (beats_done < RANDOM_BEATS * 4 / 5) && ($urandom_range(0, 3) != 0);
      random_config(1'b0);
      for (int c = 0; c < $urandom_range(1, 6); c++) begin
        if ($urandom_range(0, 9) == 0) n = $urandom_range(49, 300);
        else n = $urandom_range(1, 48);

        // random bytes with whole or partial keyword copies mixed in
        bytes_q.delete();
        span = (key_len > KEY_MAX) ? KEY_MAX : int'(key_len);
        while (bytes_q.size() < n) begin
          if (mode_sel != MODE_RESET && span > 0 && $urandom_range(0, 5) == 0) begin
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : span;
            for (int k = 0; k < cut; k++) bytes_q.push_back(key_bits[8 * k +: 8]);
          end else begin
            rb = 8'($urandom_range(0, 255));
            if (mode_sel == MODE_RESET) rb[7] = 1'b0;
            bytes_q.push_back(rb);
          end
        end

        // stray reads before the chunk are dropped
        if ($urandom_range(0, 7) == 0) begin
          send_beat(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          beats_done++;
        end

        for (int k = 0; k < n; k++) begin
          // occasional register change in the middle of a chunk
          if (n >= 8 && k == n / 2 && $urandom_range(0, 7) == 0) begin
            wait_idle();
            random_config(1'b1);
          end
          last = (k == n - 1);
          send_beat(OP_WRITE, bytes_q[k], last);
          beats_done++;
        end

        for (int k = 0; k < n; k++) begin
          // stray writes during the drain are dropped
          if ($urandom_range(0, 11) == 0) begin
            send_beat(OP_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            beats_done++;
          end
          send_beat(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          beats_done++;
        end
      end
    end
  endtask

  // reset mode hit drops the chunk and the block stays closed for good
  task automatic test_reset_on_match();
    gaps_on = 1'b0;
    wait_idle();
    set_config(64'hC3, 64'h0, 5'd1, MODE_RESET, 8'd20);
    send_beat(OP_WRITE, 8'h11, 1'b0);
    send_beat(OP_WRITE, 8'hC3, 1'b0);
    send_beat(OP_WRITE, 8'h22, 1'b1);
    repeat (6)
      send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_mask_clipping();
    test_pass_through();
    test_random_traffic();
    test_reset_on_match();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
